// File: hw/rtl/swm_pkg.sv
// Shared types, constants and command structs for the sliding window median block.
package swm_pkg;

  localparam int unsigned MaxWindowDefault  = 64;
  localparam int unsigned SampleBitsDefault = 32;
  localparam int unsigned CfgBits           = 7;

  typedef enum logic [2:0] {
    StIdle,
    StDrop,
    StDropShift,
    StInsert,
    StEmit
  } swm_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;       // latch the accepted item, apply restart
    logic drop_find;  // locate the oldest sample in the sorted cells
    logic drop_shift; // remove the located cell
    logic insert;     // shift-insert the new sample, write the ring
    logic emit;       // load the median into the output register
  } swm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;       // fill count has reached the window size
    logic exact;      // fill count equals the window size
  } swm_sts_t;

endpackage

// File: hw/rtl/swm_if.sv
// Valid/ready stream interface carrying one payload.
interface swm_if #(
  parameter int unsigned Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/swm_datapath.sv
// Datapath: arrival ring memory, sorted cell array, fill count and output register.
module swm_datapath
  import swm_pkg::*;
#(
  parameter int unsigned MaxWindow  = MaxWindowDefault,
  parameter int unsigned SampleBits = SampleBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [CfgBits-1:0]           win_i,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic                         restart_i,
  input  swm_cmd_t                     cmd_i,
  output swm_sts_t                     sts_o,
  output logic signed [SampleBits-1:0] median_o
);

  localparam int unsigned PtrBits = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned CntBits = $clog2(MaxWindow + 1);

  logic [SampleBits-1:0] ring_mem [MaxWindow];
  logic [SampleBits-1:0] cell_q [MaxWindow];
  logic [SampleBits-1:0] key_q, ring_rd_q;
  logic [CntBits-1:0]    fill_q;
  logic [PtrBits-1:0]    old_q;
  logic [CntBits-1:0]    weff;
  logic [MaxWindow-1:0]  le_vec, hit_vec, hit_first, hit_q;
  logic [PtrBits-1:0]    wr_ptr, rd_ptr, med_idx;
  logic [CntBits:0]      wsum;

  // Clamp window size to 1..MaxWindow.
  always_comb begin
    if (win_i == '0) begin
      weff = CntBits'(1);
    end else if ({{(32-CfgBits){1'b0}}, win_i} > 32'(MaxWindow)) begin
      weff = CntBits'(MaxWindow);
    end else begin
      weff = CntBits'(win_i);
    end
  end

  assign sts_o.full  = fill_q >= weff;
  assign sts_o.exact = fill_q == weff;
  assign wsum        = {1'b0, weff} + {(CntBits+1){1'b1}};
  assign med_idx     = PtrBits'(wsum >> 1);

  // Ring address wraps at MaxWindow; the sum stays below twice the depth.
  always_comb begin
    logic [CntBits:0] s;
    s = {1'b0, CntBits'(old_q)} + {1'b0, fill_q};
    if (s >= (CntBits+1)'(MaxWindow)) begin
      s = s - (CntBits+1)'(MaxWindow);
    end
    wr_ptr = PtrBits'(s);
    if ({1'b0, CntBits'(old_q)} + 1'b1 >= (CntBits+1)'(MaxWindow)) begin
      rd_ptr = '0;
    end else begin
      rd_ptr = old_q + 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxWindow; i++) begin
      le_vec[i]  = (CntBits'(i) < fill_q) && (cell_q[i] <= key_q);
      hit_vec[i] = (CntBits'(i) < fill_q) && (cell_q[i] == ring_rd_q);
    end
    hit_first = hit_vec & ~(hit_vec - 1'b1);
  end

  // Ring memory: one write, one registered read of the oldest entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      ring_mem[wr_ptr] <= key_q;
    end
    ring_rd_q <= ring_mem[(cmd_i.take || cmd_i.drop_shift) ? (cmd_i.take ? old_q : rd_ptr)
                                                             : old_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      key_q <= {~sample_i[SampleBits-1], sample_i[SampleBits-2:0]};
    end
    if (cmd_i.drop_find) begin
      hit_q <= hit_first;
    end
    if (cmd_i.emit) begin
      median_o <= {~cell_q[med_idx][SampleBits-1], cell_q[med_idx][SampleBits-2:0]};
    end
    for (int i = 0; i < MaxWindow; i++) begin
      if (cmd_i.drop_shift) begin
        // Cells at or above the found copy take their upper neighbor.
        if ((hit_q & ((MaxWindow'(1) << i) - 1'b1)) != '0 || hit_q[i]) begin
          if (i < MaxWindow - 1) begin
            cell_q[i] <= cell_q[(i < MaxWindow - 1) ? i + 1 : i];
          end
        end
      end else if (cmd_i.insert) begin
        // Cells past the insert point move up one; the insert point takes the key.
        if (!le_vec[i]) begin
          if (i == 0) begin
            cell_q[i] <= key_q;
          end else if (le_vec[(i > 0) ? i - 1 : 0]) begin
            cell_q[i] <= key_q;
          end else begin
            cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      old_q  <= '0;
    end else begin
      if (cmd_i.take && restart_i) begin
        fill_q <= '0;
        old_q  <= '0;
      end else if (cmd_i.drop_shift) begin
        fill_q <= fill_q - 1'b1;
        old_q  <= rd_ptr;
      end else if (cmd_i.insert) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/swm_ctrl.sv
// Controller: sequences take, drop, insert and emit for each item; drop and emit only once the window is full.
module swm_ctrl
  import swm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  swm_sts_t sts_i,
  output swm_cmd_t cmd_o
);

  swm_state_e state_q, state_d;
  logic       ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:      if (in_valid_i) state_d = StDrop;
      StDrop:      state_d = sts_i.full ? StDropShift : StInsert;
      StDropShift: state_d = StDrop;
      StInsert:    state_d = StEmit;
      StEmit:      if (!(sts_i.exact && ov_q && !out_ready_i)) state_d = StIdle;
      default:     state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    in_ready_o       = 1'b0;
    ov_d             = ov_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.take  = in_valid_i;
      end
      StDrop:      cmd_o.drop_find  = sts_i.full;
      StDropShift: cmd_o.drop_shift = 1'b1;
      StInsert:    cmd_o.insert     = 1'b1;
      StEmit: begin
        // Hold the new median here while the previous one still waits.
        if (sts_i.exact && (!ov_q || out_ready_i)) begin
          cmd_o.emit = 1'b1;
          ov_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

// File: hw/rtl/sliding_window_median_core.sv
// Top level of the sliding window median filter.
// Running lower-median filter over the last window_size samples (1..MaxWindow, 0 acts as 1).
// Per item: take, then per sample dropped from the window (normally one) a ring memory
// read and sorted cell shift to remove it, then insert, and emit once the window is full.
// A result waits in the output register while the next item is taken and worked on; that
// item holds at emit until the register is taken. No clearing pass is needed after reset.
module sliding_window_median_core
  import swm_pkg::*;
#(
  parameter int unsigned MaxWindow  = MaxWindowDefault,
  parameter int unsigned SampleBits = SampleBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgBits-1:0] cfg_wdata_i,
  swm_if.sink                in_ch,
  swm_if.source              out_ch
);

  logic [CfgBits-1:0] win_q;
  swm_cmd_t           cmd;
  swm_sts_t           sts;
  logic               ov;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= CfgBits'(3);
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  swm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid), .in_ready_o (in_ch.ready),
    .out_valid_o(ov), .out_ready_i(out_ch.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  assign out_ch.valid = ov;

  swm_datapath #(.MaxWindow(MaxWindow), .SampleBits(SampleBits)) u_dp (
    .clk_i, .rst_ni,
    .win_i(win_q),
    .sample_i(in_ch.data[SampleBits-1:0]),
    .restart_i(in_ch.data[SampleBits]),
    .cmd_i(cmd), .sts_o(sts),
    .median_o(out_ch.data)
  );

endmodule

// File: hw/rtl/swm_checker.sv
// Port-level assertions for the sliding window median core, bound to the top level.
module swm_checker #(
  parameter int unsigned Width = 32
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [Width-1:0] out_data_i
);
  // An item accepted is never taken again the next cycle.
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("back to back accept");
  // A result only appears right after the core has held its input not ready.
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i)) else $error("result without work");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
  // A waiting result keeps its value.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i)) else $error("result changed");
endmodule

bind sliding_window_median_core swm_checker #(.Width(SampleBits)) u_chk (
  .clk_i, .rst_ni,
  .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready),
  .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready),
  .out_data_i(out_ch.data)
);

// File: bench/sliding_window_median_core_tb.sv
// Self-checking bench for the sliding window median core: directed and random sample streams.
module sliding_window_median_core_tb
  import swm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxWin  = MaxWindowDefault;
  localparam int unsigned SBits   = SampleBitsDefault;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned SettleCycles = 4 + 2 * MaxWin + 64;

  typedef logic signed [SBits-1:0] sample_t;

  // Running lower-median predictor with its own window state and expected medians.
  class median_scoreboard;
    sample_t         ring [MaxWin];
    sample_t         sorted [MaxWin];
    int unsigned     fill;
    int unsigned     oldest;
    logic [CfgBits-1:0] win_reg;
    sample_t         medians_due [$];
    int unsigned     mismatches;

    function new();
      fill = 0;
      oldest = 0;
      win_reg = 3;
      mismatches = 0;
    endfunction

    function void set_window(logic [CfgBits-1:0] v);
      win_reg = v;
    endfunction

    function int unsigned span();
      if (win_reg == 0) return 1;
      if (win_reg > MaxWin) return MaxWin;
      return win_reg;
    endfunction

    function void drop_oldest();
      sample_t gone;
      int unsigned i;
      int unsigned j;
      gone = ring[oldest];
      for (i = 0; i < fill; i++) begin
        if (sorted[i] == gone) begin
          for (j = i; j + 1 < fill; j++) sorted[j] = sorted[j+1];
          break;
        end
      end
      oldest = (oldest + 1) % MaxWin;
      fill--;
    endfunction

    function void note_sample(sample_t s, logic restart);
      int unsigned w;
      int unsigned pos;
      int unsigned j;
      w = span();
      if (restart) begin
        fill = 0;
        oldest = 0;
      end
      while (fill >= w) drop_oldest();
      ring[(oldest + fill) % MaxWin] = s;
      pos = 0;
      while (pos < fill && sorted[pos] <= s) pos++;
      for (j = fill; j > pos; j--) sorted[j] = sorted[j-1];
      sorted[pos] = s;
      fill++;
      if (fill == w) medians_due = {medians_due, sorted[(w - 1) / 2]};
    endfunction

    function void check_median(logic [SBits-1:0] got);
      sample_t want;
      if (medians_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected median %0d", $signed(got));
        return;
      end
      want = medians_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("median mismatch: expected %0d, got %0d", want, $signed(got));
      end
    endfunction

    function int unsigned pending();
      return medians_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgBits-1:0] cfg_wdata_i;

  swm_if #(.Width(SBits + 1)) in_ch ();
  swm_if #(.Width(SBits)) out_ch ();

  sliding_window_median_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source)
  );

  median_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  int unsigned idle_count;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Inputs and outputs are stable at the falling edge; a handshake seen here lands next rise.
  always @(negedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      sb.note_sample(in_ch.data[SBits-1:0], in_ch.data[SBits]);
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_median(out_ch.data);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_count = 0;
    else idle_count++;
    if (idle_count > IdleLimit) begin
      $display("sliding_window_median_core_tb NOT OK");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  task automatic send_sample(sample_t s, logic restart);
    bit took;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= {restart, s};
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Hold the input until every median is out, then let the core settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_window(logic [CfgBits-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_window(v);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return sample_t'($signed($urandom_range(0, 8)) - 4);
      2: return $urandom_range(0, 1) ? 32'h7fff_fffe + $urandom_range(0, 1)
                                     : 32'h8000_0000 + $urandom_range(0, 1);
      default: return sample_t'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic random_run(int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      send_sample(rand_sample(), $urandom_range(0, 40) == 0);
  endtask

  initial begin
    logic [CfgBits-1:0] sizes [12];
    sizes       = '{64, 2, 127, 0, 1, 17, 5, 96, 64, 3, 33, 8};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    quiet       = 0;
    hold_req    = 0;
    idle_count  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default window of three: extremes, duplicates, restart mid-window.
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(5, 1'b1);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-5, 1'b0);
    // Window of one passes samples through; zero acts as one.
    write_window(1);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    write_window(0);
    send_sample(-1, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    // Oversized window saturates, then shrink with a full window.
    write_window(127);
    for (int i = 0; i < 66; i++) send_sample(i[0] ? -i : i, 1'b0);
    write_window(2);
    send_sample(7, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    write_window(4);
    send_sample(1, 1'b1);
    send_sample(1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(0, 1'b0);

    for (int p = 0; p < 12; p++) begin
      write_window(sizes[p]);
      if (p == 3) begin
        // Stall the output long enough for the core to back up its input.
        hold_req = 1;
        random_run(40);
        drain();
      end
      if (p == 10) quiet = 1;
      random_run(90);
    end
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("sliding_window_median_core_tb OK");
    end else begin
      $display("sliding_window_median_core_tb NOT OK");
    end
    $finish;
  end
endmodule

// File: sliding_window_median_core.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_if.sv
hw/rtl/swm_datapath.sv
hw/rtl/swm_ctrl.sv
hw/rtl/sliding_window_median_core.sv
hw/rtl/swm_checker.sv
bench/sliding_window_median_core_tb.sv
